FILE: rtl/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared types, constants and small calendar helpers for the epoch to
// calendar converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

	// Time of day divisors
	localparam logic [17:0] SEC_PER_DAY  = 18'd86400;
	localparam logic [17:0] SEC_PER_HOUR = 18'd3600;
	localparam logic [17:0] SEC_PER_MIN  = 18'd60;

	// Reciprocals for the odd parts of the divisors, rounded up:
	// 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15.
	// Each is exact over the full range of its shifted dividend.
	localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675
	localparam logic [13:0] HOUR_RECIP = 14'd9321;      // 2^21 / 225
	localparam logic [10:0] MIN_RECIP  = 11'd1093;      // 2^14 / 15

	// Calendar constants
	localparam logic [11:0] BASE_YEAR     = 12'd1970;
	localparam logic [11:0] OFFSET_YEAR   = 12'd2000;
	localparam logic [11:0] CENTURY_2100  = 12'd2100;
	localparam logic [8:0]  DAYS_LEAP     = 9'd366;
	localparam logic [8:0]  DAYS_COMMON   = 9'd365;
	localparam logic [16:0] EPOCH_WEEKDAY = 17'd4;   // 1970-01-01 was a Thursday
	localparam logic [3:0]  MONTH_FEB     = 4'd2;
	localparam logic [3:0]  MONTH_LAST    = 4'd12;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// One classified transaction handed from front to back
	typedef struct packed {
		logic [15:0] days;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [2:0]  weekday;
	} e2c_item_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} e2c_qstat_t;

	// Gregorian leap rule over the reachable span 1970..2106: the only
	// century years in it are 2000 (leap, multiple of 400) and 2100 (not leap).
	function automatic logic is_leap(input logic [11:0] y);
		return (y[1:0] == 2'b00) && (y != CENTURY_2100);
	endfunction

	// Length of a month, 1 = January
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2:                 len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:              len = 5'd31;
		endcase
		return len;
	endfunction

	// Residue modulo 7 by folding octal digits (8 = 1 mod 7)
	function automatic logic [2:0] mod7(input logic [16:0] v);
		logic [5:0] s1;
		logic [3:0] s2;
		s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
			+ 6'(v[14:12]) + 6'(v[16:15]);
		s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
		if (s2 >= 4'd7)
			s2 = s2 - 4'd7;
		return s2[2:0];
	endfunction

endpackage

FILE: rtl/epoch_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar
// Converts a 32-bit Unix second count into UTC time of day, weekday and
// Gregorian date.
// ----------------------------------------------------------------------------
// Usage:
//   Drive epoch_seconds and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low. busy then stays high
//   while the front splits the count (one reciprocal multiply or one
//   subtract per cycle for days, hours, minutes and seconds, then the
//   push), and stays high in the push state while the queue is full.
//   The back part pops the queue and strips one year per cycle from 1970,
//   then one month per cycle. That loop sets the sustained rate; the
//   front works on the next count meanwhile. With the back idle, the time
//   to done depends on the date; earlier transactions still in the back
//   add their time.
//   Each result is registered on the output ports and marked by done for
//   exactly one cycle; the receiver must take it then, there is no stall.
//   Reset (arst_n low) empties the queue and drops any transaction in
//   flight; no result is produced for it.
// ----------------------------------------------------------------------------
module epoch_to_calendar
	import e2c_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [31:0]       epoch_seconds,
	output logic              done,
	output logic [4:0]        hour,
	output logic [5:0]        minute,
	output logic [5:0]        second,
	output logic [2:0]        weekday,
	output logic [11:0]       year,
	output logic signed [7:0] year_offset,
	output logic [3:0]        month,
	output logic [4:0]        day_of_month
);

	e2c_qstat_t qstat;
	e2c_item_t  push_item;
	e2c_item_t  pop_item;
	logic       push;
	logic       pop;

	// Divide front
	e2c_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.epoch_seconds (epoch_seconds),
		.busy          (busy),
		.qstat         (qstat),
		.push          (push),
		.push_item     (push_item)
	);

	// Decoupling queue
	e2c_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	// Calendar back
	e2c_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.pop_item     (pop_item),
		.pop          (pop),
		.done         (done),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.weekday      (weekday),
		.year         (year),
		.year_offset  (year_offset),
		.month        (month),
		.day_of_month (day_of_month)
	);

	// Accepted transaction always starts the divider
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("front did not go busy after accepting a transaction");

	// Result strobe is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// Divider remainders stay in range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60) && (weekday < 3'd7))
		else $error("time of day or weekday out of range");

	// Month stripping leaves a legal date
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month != 4'd0) && (month <= MONTH_LAST) && (day_of_month != 5'd0))
		else $error("month or day out of range");

endmodule

FILE: rtl/e2c_front.sv
// ----------------------------------------------------------------------------
// e2c_front
// Accepts a second count and splits it into whole days, hours, minutes and
// seconds, one reciprocal multiply or one back-subtract per cycle.
// ----------------------------------------------------------------------------
module e2c_front
	import e2c_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [31:0]  epoch_seconds,
	output logic         busy,
	input  e2c_qstat_t   qstat,
	output logic         push,
	output e2c_item_t    push_item
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_DAY  = 3'd1;
	localparam logic [2:0] F_TOD  = 3'd2;
	localparam logic [2:0] F_HOUR = 3'd3;
	localparam logic [2:0] F_HREM = 3'd4;
	localparam logic [2:0] F_MIN  = 3'd5;
	localparam logic [2:0] F_SEC  = 3'd6;
	localparam logic [2:0] F_PUSH = 3'd7;

	logic [2:0]  state_q;
	logic [31:0] ep_q;
	logic [15:0] days_q;
	logic [16:0] tod_q;
	logic [4:0]  hour_q;
	logic [11:0] rem_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;

	logic [50:0] day_prod;
	logic [31:0] day_secs;
	logic [31:0] tod_diff;
	logic [25:0] hour_prod;
	logic [16:0] hour_secs;
	logic [16:0] hrem_diff;
	logic [19:0] min_prod;
	logic [11:0] min_secs;
	logic [11:0] sec_diff;

	// Days: drop the power of two, then multiply by the reciprocal of 675
	assign day_prod = 51'(ep_q[31:7]) * 51'(DAY_RECIP);
	assign day_secs = 32'(days_q) * 32'(SEC_PER_DAY);
	assign tod_diff = ep_q - day_secs;

	// Hours: seconds of the day over 16, times the reciprocal of 225
	assign hour_prod = 26'(tod_q[16:4]) * 26'(HOUR_RECIP);
	assign hour_secs = 17'(hour_q) * 17'(SEC_PER_HOUR);
	assign hrem_diff = tod_q - hour_secs;

	// Minutes: seconds of the hour over 4, times the reciprocal of 15
	assign min_prod = 20'(rem_q[11:2]) * 20'(MIN_RECIP);
	assign min_secs = 12'(minute_q) * 12'(SEC_PER_MIN);
	assign sec_diff = rem_q - min_secs;

	// Phase sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start)
						state_q <= F_DAY;
				end
				F_DAY:  state_q <= F_TOD;
				F_TOD:  state_q <= F_HOUR;
				F_HOUR: state_q <= F_HREM;
				F_HREM: state_q <= F_MIN;
				F_MIN:  state_q <= F_SEC;
				F_SEC:  state_q <= F_PUSH;
				F_PUSH: begin
					if (!qstat.full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Split datapath, one step per phase
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: ep_q     <= epoch_seconds;
			F_DAY:  days_q   <= day_prod[50:35];
			F_TOD:  tod_q    <= tod_diff[16:0];
			F_HOUR: hour_q   <= hour_prod[25:21];
			F_HREM: rem_q    <= hrem_diff[11:0];
			F_MIN:  minute_q <= min_prod[19:14];
			F_SEC:  second_q <= sec_diff[5:0];
			default: ;
		endcase
	end

	assign busy = (state_q != F_IDLE);
	assign push = (state_q == F_PUSH) && !qstat.full;

	// Weekday from the whole day count
	always_comb begin
		push_item.days    = days_q;
		push_item.hour    = hour_q;
		push_item.minute  = minute_q;
		push_item.second  = second_q;
		push_item.weekday = mod7(17'(days_q) + EPOCH_WEEKDAY);
	end

endmodule

FILE: rtl/e2c_queue.sv
// ----------------------------------------------------------------------------
// e2c_queue
// Small register queue that decouples the divide front from the calendar
// back.
// ----------------------------------------------------------------------------
module e2c_queue
	import e2c_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  e2c_item_t  push_item,
	input  logic       pop,
	output e2c_item_t  pop_item,
	output e2c_qstat_t qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	e2c_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	assign pop_item    = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);

endmodule

FILE: rtl/e2c_back.sv
// ----------------------------------------------------------------------------
// e2c_back
// Takes a day count off the queue, strips whole years from 1970 and then
// whole months, and registers the result, marked by a one-cycle done.
// ----------------------------------------------------------------------------
module e2c_back
	import e2c_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  e2c_qstat_t        qstat,
	input  e2c_item_t         pop_item,
	output logic              pop,
	output logic              done,
	output logic [4:0]        hour,
	output logic [5:0]        minute,
	output logic [5:0]        second,
	output logic [2:0]        weekday,
	output logic [11:0]       year,
	output logic signed [7:0] year_offset,
	output logic [3:0]        month,
	output logic [4:0]        day_of_month
);

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_YEAR  = 2'd1;
	localparam logic [1:0] B_MONTH = 2'd2;

	logic [1:0]  state_q;
	logic        done_q;
	e2c_item_t   item_q;
	logic [15:0] days_q;
	logic [11:0] year_q;
	logic [3:0]  month_q;

	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic [2:0]  weekday_q;
	logic [11:0] year_out_q;
	logic [7:0]  year_off_q;
	logic [3:0]  month_out_q;
	logic [4:0]  dom_q;

	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;
	logic        year_fits;
	logic        month_stop;
	logic [11:0] year_diff;

	assign leap       = is_leap(year_q);
	assign ylen       = leap ? DAYS_LEAP : DAYS_COMMON;
	assign mlen       = month_len(month_q, leap);
	assign year_fits  = (days_q >= 16'(ylen));
	assign month_stop = (days_q < 16'(mlen)) || (month_q == MONTH_LAST);
	assign year_diff  = year_q - OFFSET_YEAR;
	assign pop        = (state_q == B_IDLE) && !qstat.empty;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!qstat.empty)
						state_q <= B_YEAR;
				end
				B_YEAR: begin
					if (!year_fits)
						state_q <= B_MONTH;
				end
				B_MONTH: begin
					if (month_stop) begin
						state_q <= B_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Year and month stripping datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				item_q  <= pop_item;
				days_q  <= pop_item.days;
				year_q  <= BASE_YEAR;
				month_q <= 4'd1;
			end
			B_YEAR: begin
				if (year_fits) begin
					days_q <= days_q - 16'(ylen);
					year_q <= year_q + 12'd1;
				end
			end
			B_MONTH: begin
				if (month_stop) begin
					hour_q      <= item_q.hour;
					minute_q    <= item_q.minute;
					second_q    <= item_q.second;
					weekday_q   <= item_q.weekday;
					year_out_q  <= year_q;
					year_off_q  <= year_diff[7:0];
					month_out_q <= month_q;
					dom_q       <= days_q[4:0] + 5'd1;
				end else begin
					days_q  <= days_q - 16'(mlen);
					month_q <= month_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign hour         = hour_q;
	assign minute       = minute_q;
	assign second       = second_q;
	assign weekday      = weekday_q;
	assign year         = year_out_q;
	assign year_offset  = signed'(year_off_q);
	assign month        = month_out_q;
	assign day_of_month = dom_q;

endmodule
